@@ src/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list package
// Request and result types, operation kinds, status codes and cell commands.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_WORD_BITS = 32;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] K_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] K_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] K_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] K_INSERT = 3'd4;
  localparam logic [KIND_W-1:0] K_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CMD_HOLD   = 2'd0;
  localparam cell_cmd_t CMD_APPEND = 2'd1;
  localparam cell_cmd_t CMD_INSERT = 2'd2;
  localparam cell_cmd_t CMD_DELETE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [POS_W-1:0]          found_position;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
  } out_t;

endpackage

@@ src/olist_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list word, shifts with its neighbors, compares and selects reads.
// ----------------------------------------------------------------------------
module olist_cell #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = olist_pkg::DEF_WORD_BITS,
  parameter int XW        = 5
) (
  input  logic                  clk,
  input  olist_pkg::cell_cmd_t  cmd,
  input  logic [XW-1:0]         pos,
  input  logic [XW-1:0]         count,
  input  logic [WORD_BITS-1:0]  key,
  input  logic [WORD_BITS-1:0]  word_lo,
  input  logic [WORD_BITS-1:0]  word_hi,
  output logic [WORD_BITS-1:0]  word_o,
  output logic                  match_o,
  output logic [WORD_BITS-1:0]  rd_o
);

  localparam logic [XW-1:0] MY_IDX = XW'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (cmd)
      olist_pkg::CMD_APPEND: begin
        if (MY_IDX == count) word_nxt = key;
      end
      olist_pkg::CMD_INSERT: begin
        if (MY_IDX == pos) word_nxt = key;
        else if (MY_IDX > pos) word_nxt = word_lo;
      end
      olist_pkg::CMD_DELETE: begin
        if (MY_IDX >= pos) word_nxt = word_hi;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o  = word_r;
  assign match_o = (MY_IDX < count) && (word_r == key);
  assign rd_o    = (MY_IDX == pos) ? word_r : '0;

endmodule

@@ src/ordered_list_insert_delete_search.sv @@
// Sequencing: a taken request runs in the execute state, then the post state;
// a search passes through the search state between them. The block takes one
// request at a time (in_ready only in idle); a stalled output holds the sequencer.
// All list words shift, compare and select in parallel in the execute state.
// Reset: synchronous active-low rst_n clears count, sequencer and output valid;
// list words are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and search
// Chain of word cells with a small sequencer and a registered result.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_search #(
  parameter int CAPACITY  = olist_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = olist_pkg::DEF_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  olist_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output olist_pkg::out_t  out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0]            state_r, state_nxt;
  olist_pkg::in_t        req_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CAPACITY-1:0]   match_r;
  olist_pkg::out_t       res_r, res_nxt;
  olist_pkg::out_t       out_r;
  logic                  out_valid_r, out_valid_nxt;

  olist_pkg::cell_cmd_t  cmd;
  logic [XW-1:0]         pos_x, cnt_x;
  logic [WORD_BITS-1:0]  key;
  logic [WORD_BITS-1:0]  words [CAPACITY];
  logic [WORD_BITS-1:0]  rds   [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [WORD_BITS-1:0]  rd_or;
  logic [IW-1:0]         first_idx;
  logic                  any_match;

  assign pos_x = XW'(req_r.position);
  assign cnt_x = XW'(count_r);
  assign key   = WORD_BITS'(req_r.value);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] lo_w, hi_w;
    if (g > 0) begin : g_lo
      assign lo_w = words[g-1];
    end else begin : g_lo0
      assign lo_w = '0;
    end
    if (g < CAPACITY - 1) begin : g_hi
      assign hi_w = words[g+1];
    end else begin : g_hi0
      assign hi_w = '0;
    end
    olist_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS),
      .XW        (XW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (pos_x),
      .count   (cnt_x),
      .key     (key),
      .word_lo (lo_w),
      .word_hi (hi_w),
      .word_o  (words[g]),
      .match_o (match[g]),
      .rd_o    (rds[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  always_comb begin
    first_idx = '0;
    any_match = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = IW'(i);
        any_match = 1'b1;
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    cmd           = olist_pkg::CMD_HOLD;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt.status         = olist_pkg::ST_OK;
        res_nxt.found_position = '0;
        res_nxt.read_value     = '0;
        state_nxt              = S_POST;
        unique case (req_r.kind)
          olist_pkg::K_CLEAR: begin
            count_nxt = '0;
          end
          olist_pkg::K_APPEND: begin
            if (count_r >= CW'(CAPACITY)) begin
              res_nxt.status = olist_pkg::ST_FULL;
            end else begin
              cmd       = olist_pkg::CMD_APPEND;
              count_nxt = count_r + 1'b1;
            end
          end
          olist_pkg::K_DELETE: begin
            if (count_r == '0) begin
              res_nxt.status = olist_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              res_nxt.status = olist_pkg::ST_BADPOS;
            end else begin
              cmd       = olist_pkg::CMD_DELETE;
              count_nxt = count_r - 1'b1;
            end
          end
          olist_pkg::K_SEARCH: begin
            state_nxt = S_SRCH;
          end
          olist_pkg::K_INSERT: begin
            if (count_r >= CW'(CAPACITY)) begin
              res_nxt.status = olist_pkg::ST_FULL;
            end else if (pos_x > cnt_x) begin
              res_nxt.status = olist_pkg::ST_BADPOS;
            end else begin
              cmd       = olist_pkg::CMD_INSERT;
              count_nxt = count_r + 1'b1;
            end
          end
          olist_pkg::K_READ: begin
            if (count_r == '0) begin
              res_nxt.status = olist_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              res_nxt.status = olist_pkg::ST_BADPOS;
            end else begin
              res_nxt.read_value = olist_pkg::VALUE_W'(rd_or);
            end
          end
          default: begin
          end
        endcase
        res_nxt.count = olist_pkg::COUNT_W'(count_nxt);
      end
      S_SRCH: begin
        if (any_match) begin
          res_nxt.status         = olist_pkg::ST_OK;
          res_nxt.found_position = olist_pkg::POS_W'(first_idx);
        end else begin
          res_nxt.status         = olist_pkg::ST_NOTFOUND;
          res_nxt.found_position = '0;
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (state_r == S_EXEC) match_r <= match;
    res_r <= res_nxt;
    if (state_r == S_POST && (!out_valid_r || out_ready)) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request not executed");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && req_r.kind == olist_pkg::K_CLEAR) |=> (count_r == '0))
    else $error("clear left a nonzero count");

  a_post_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result not issued from post state");
`endif

endmodule
